@@ rtl/mlfq_pkg.sv @@
// Package: shared types, constants and command codes of the feedback-queue scheduler.
package mlfq_pkg;
  localparam int unsigned NumLevelsDef = 4;
  localparam int unsigned MaxTasksDef  = 16;

  typedef enum logic [2:0] {
    CMD_LOAD    = 3'd0,
    CMD_UNBLOCK = 3'd1,
    CMD_TICK    = 3'd2,
    CMD_BLOCK   = 3'd3,
    CMD_EXIT    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_LEVELS = 3'd0,
    REG_Q0     = 3'd1,
    REG_Q1     = 3'd2,
    REG_Q2     = 3'd3,
    REG_Q3     = 3'd4
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_DECIDE, S_READ, S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] task_id;
    logic [7:0] running_id;
    logic       running_idle;
  } in_item_t;

  typedef struct packed {
    logic [7:0] chosen_id;
    logic       chosen_idle;
    logic [1:0] status;
  } out_item_t;
endpackage

@@ rtl/mlfq_if.sv @@
// Interfaces: valid/ready channels for scheduler command and result items.
interface mlfq_in_if;
  logic                 valid;
  logic                 ready;
  mlfq_pkg::in_item_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mlfq_out_if;
  logic                 valid;
  logic                 ready;
  mlfq_pkg::out_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/multilevel_feedback_queue_scheduler_core.sv @@
// Multilevel feedback queue scheduler: top level with control sequencer.
//
// Channels: cmd_in (sink) carries one scheduler event per item: load,
// unblock, tick, block or exit, with the task id and the running task.
// res_out (source) carries one result item per event: the task to run
// next (or idle) and a status code. Configuration is a plain write port:
// cfg_we_i, cfg_idx_i (0 levels in use, 1..4 quantum of level 0..3) and
// cfg_data_i; write only while no event is in flight.
// An event is taken in IDLE and passes DECIDE, READ and OUT; OUT loads
// the result register. Unblock, and block of a running task, first walk
// the blocked-task table in SEARCH, one slot a cycle. A dispatch reads
// the head of the chosen level from the ready-id memory, whose read port
// is registered: the address is set in READ and the data taken in OUT.
// One event is in flight at a time; the next is taken once the result
// register has been handed on.
// Reset empties all queues and the blocked table, sets the running level
// to 0 and the quantum counter to 0. When the receiver stalls, the
// result is held in the output register and no new event is taken until
// it is accepted.
module multilevel_feedback_queue_scheduler_core #(
  parameter int unsigned NUM_LEVELS = mlfq_pkg::NumLevelsDef,
  parameter int unsigned MAX_TASKS  = mlfq_pkg::MaxTasksDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  mlfq_in_if.sink     cmd_in,
  mlfq_out_if.source  res_out
);
  localparam int unsigned LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int unsigned TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned SW = $clog2(MAX_TASKS + 1);
  localparam int unsigned AW = LW + TW;

  // configuration
  logic [2:0]  levels_q;
  logic [15:0] quant_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q   <= 3'd4;
      quant_q[0] <= 16'd1;
      quant_q[1] <= 16'd2;
      quant_q[2] <= 16'd4;
      quant_q[3] <= 16'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mlfq_pkg::REG_LEVELS: levels_q <= cfg_data_i[2:0];
        mlfq_pkg::REG_Q0:     quant_q[0] <= cfg_data_i;
        mlfq_pkg::REG_Q1:     quant_q[1] <= cfg_data_i;
        mlfq_pkg::REG_Q2:     quant_q[2] <= cfg_data_i;
        mlfq_pkg::REG_Q3:     quant_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [LW-1:0] last;
  always_comb begin
    if (levels_q == 3'd0) begin
      last = '0;
    end else if (32'(levels_q) > NUM_LEVELS) begin
      last = LW'(NUM_LEVELS - 1);
    end else begin
      last = LW'(levels_q - 3'd1);
    end
  end

  function automatic logic [15:0] quant_of(input logic [2:0] lvl,
                                           input logic [15:0] q0, input logic [15:0] q1,
                                           input logic [15:0] q2, input logic [15:0] q3);
    logic [15:0] r;
    priority case (1'b1)
      lvl == 3'd0: r = q0;
      lvl == 3'd1: r = q1;
      lvl == 3'd2: r = q2;
      default:     r = q3;
    endcase
    return r;
  endfunction

  // scheduler state
  logic [TW-1:0]  head_q  [NUM_LEVELS];
  logic [CW-1:0]  count_q [NUM_LEVELS];
  logic [MAX_TASKS-1:0] bvalid_q;
  logic [7:0]     btask_q [MAX_TASKS];
  logic [LW-1:0]  blevel_q [MAX_TASKS];
  logic [LW-1:0]  cur_lvl_q;
  logic [15:0]    qleft_q;

  mlfq_pkg::state_e   state_q, state_d;
  mlfq_pkg::in_item_t item_q;
  logic [SW-1:0]      scan_q;
  logic               found_q;
  logic [TW-1:0]      slot_q;
  logic               go_q;
  logic [1:0]         status_q;
  logic               disp_any_q;
  logic               out_valid_q;
  mlfq_pkg::out_item_t out_q;

  // ready memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  mlfq_ready_mem #(.AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign cmd_in.ready    = (state_q == mlfq_pkg::S_IDLE) && !out_valid_q;
  assign res_out.valid   = out_valid_q;
  assign res_out.payload = out_q;

  logic accept;
  assign accept = cmd_in.valid && cmd_in.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mlfq_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd_in.payload.cmd == mlfq_pkg::CMD_UNBLOCK ||
              (cmd_in.payload.cmd == mlfq_pkg::CMD_BLOCK && !cmd_in.payload.running_idle)) begin
            state_d = mlfq_pkg::S_SEARCH;
          end else begin
            state_d = mlfq_pkg::S_DECIDE;
          end
        end
      end
      mlfq_pkg::S_SEARCH: begin
        if (32'(scan_q) == MAX_TASKS - 1) state_d = mlfq_pkg::S_DECIDE;
      end
      mlfq_pkg::S_DECIDE: state_d = mlfq_pkg::S_READ;
      mlfq_pkg::S_READ:   state_d = mlfq_pkg::S_OUT;
      mlfq_pkg::S_OUT:    state_d = mlfq_pkg::S_IDLE;
      default:            state_d = mlfq_pkg::S_IDLE;
    endcase
  end

  // enqueue target and decision of the DECIDE step
  logic          enq_en;
  logic [LW-1:0] enq_lvl;
  logic [7:0]    enq_id;
  logic          enq_ok;
  logic          dec_go;
  logic [1:0]    dec_status;
  logic [LW-1:0] ulvl;

  always_comb begin
    enq_en     = 1'b0;
    enq_lvl    = '0;
    enq_id     = item_q.task_id;
    dec_go     = 1'b0;
    dec_status = mlfq_pkg::ST_OK;
    ulvl       = (blevel_q[slot_q] == '0) ? '0 : blevel_q[slot_q] - LW'(1);
    if (ulvl > last) ulvl = last;
    unique case (item_q.cmd)
      mlfq_pkg::CMD_LOAD: begin
        enq_en = 1'b1;
      end
      mlfq_pkg::CMD_UNBLOCK: begin
        if (!found_q) begin
          dec_status = mlfq_pkg::ST_NOTFOUND;
        end else begin
          enq_en  = 1'b1;
          enq_lvl = ulvl;
        end
      end
      mlfq_pkg::CMD_TICK, mlfq_pkg::CMD_BLOCK, mlfq_pkg::CMD_EXIT: begin
        if (item_q.running_idle || item_q.cmd == mlfq_pkg::CMD_EXIT) begin
          dec_go = 1'b1;
        end else if (item_q.cmd == mlfq_pkg::CMD_TICK && qleft_q == 16'd0) begin
          enq_en  = 1'b1;
          enq_id  = item_q.running_id;
          enq_lvl = (cur_lvl_q >= last) ? last : cur_lvl_q + LW'(1);
        end else if (item_q.cmd == mlfq_pkg::CMD_BLOCK) begin
          if (found_q) dec_go = 1'b1;
          else dec_status = mlfq_pkg::ST_FULL;
        end
      end
      default: ;
    endcase
    enq_ok = enq_en && (32'(count_q[enq_lvl]) < MAX_TASKS);
    if (enq_en && !enq_ok) dec_status = mlfq_pkg::ST_FULL;
    if (enq_ok && item_q.cmd == mlfq_pkg::CMD_TICK) dec_go = 1'b1;
  end

  // dispatch level: lowest-numbered (highest-priority) non-empty level in use (counts after DECIDE)
  logic          sel_any;
  logic [LW-1:0] sel_lvl;
  always_comb begin
    sel_any = 1'b0;
    sel_lvl = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (LW'(l) <= last && count_q[l] != '0) begin
        sel_any = 1'b1;
        sel_lvl = LW'(l);
      end
    end
  end

  // tail position wraps by one compare and subtract
  logic [31:0]   wsum;
  logic [TW-1:0] wpos;
  assign wsum      = 32'(head_q[enq_lvl]) + 32'(count_q[enq_lvl]);
  assign wpos      = (wsum >= MAX_TASKS) ? TW'(wsum - MAX_TASKS) : TW'(wsum);
  assign mem_we    = (state_q == mlfq_pkg::S_DECIDE) && enq_ok;
  assign mem_waddr = AW'(32'(enq_lvl) * MAX_TASKS + 32'(wpos));
  assign mem_wdata = enq_id;
  assign mem_raddr = AW'(32'(sel_lvl) * MAX_TASKS + 32'(head_q[sel_lvl]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlfq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      bvalid_q    <= '0;
      cur_lvl_q   <= '0;
      qleft_q     <= 16'd0;
      scan_q      <= '0;
      found_q     <= 1'b0;
      go_q        <= 1'b0;
      disp_any_q  <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_q[l]  <= '0;
        count_q[l] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (res_out.valid && res_out.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        mlfq_pkg::S_IDLE: begin
          if (accept) begin
            item_q  <= cmd_in.payload;
            scan_q  <= '0;
            found_q <= 1'b0;
          end
        end
        mlfq_pkg::S_SEARCH: begin
          scan_q <= scan_q + SW'(1);
          // unblock: first valid slot holding the id; block: first free slot
          if (!found_q) begin
            if (item_q.cmd == mlfq_pkg::CMD_UNBLOCK) begin
              if (bvalid_q[scan_q[TW-1:0]] && btask_q[scan_q[TW-1:0]] == item_q.task_id) begin
                found_q <= 1'b1;
                slot_q  <= scan_q[TW-1:0];
              end
            end else if (!bvalid_q[scan_q[TW-1:0]]) begin
              found_q <= 1'b1;
              slot_q  <= scan_q[TW-1:0];
            end
          end
        end
        mlfq_pkg::S_DECIDE: begin
          go_q     <= dec_go;
          status_q <= dec_status;
          if (enq_ok) count_q[enq_lvl] <= count_q[enq_lvl] + CW'(1);
          if (enq_ok && item_q.cmd == mlfq_pkg::CMD_UNBLOCK) bvalid_q[slot_q] <= 1'b0;
          if (dec_go && item_q.cmd == mlfq_pkg::CMD_BLOCK && !item_q.running_idle) begin
            bvalid_q[slot_q] <= 1'b1;
            btask_q[slot_q]  <= item_q.running_id;
            blevel_q[slot_q] <= cur_lvl_q;
          end
          if (item_q.cmd == mlfq_pkg::CMD_TICK && !item_q.running_idle && qleft_q != 16'd0)
            qleft_q <= qleft_q - 16'd1;
        end
        mlfq_pkg::S_READ: begin
          // memory read of the selected head is in flight this cycle
          disp_any_q <= go_q && sel_any;
          if (go_q && sel_any) begin
            head_q[sel_lvl]  <= (32'(head_q[sel_lvl]) == MAX_TASKS - 1) ? '0 :
                                head_q[sel_lvl] + TW'(1);
            count_q[sel_lvl] <= count_q[sel_lvl] - CW'(1);
            cur_lvl_q        <= sel_lvl;
            qleft_q <= quant_of(3'(sel_lvl), quant_q[0], quant_q[1], quant_q[2],
                                quant_q[3]) - 16'd1;
          end
        end
        mlfq_pkg::S_OUT: begin
          out_valid_q     <= 1'b1;
          out_q.status    <= status_q;
          if (!go_q) begin
            out_q.chosen_id   <= item_q.running_id;
            out_q.chosen_idle <= item_q.running_idle;
          end else if (disp_any_q) begin
            out_q.chosen_id   <= mem_rdata;
            out_q.chosen_idle <= 1'b0;
          end else begin
            out_q.chosen_id   <= 8'd0;
            out_q.chosen_idle <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/mlfq_ready_mem.sv @@
// Ready queue store: one synchronous memory of task ids, one region per level.
module mlfq_ready_mem #(
  parameter int unsigned AW = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  logic [7:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/mlfq_checker.sv @@
// Checker: port-level properties of the scheduler core, bound to the top level.
module mlfq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input mlfq_pkg::out_item_t out_payload_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result item changed while stalled");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("item taken while result pending");
  a_one_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken back to back");
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> !out_valid_i)
    else $error("result item repeated");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_payload_i.status != 2'd3)
    else $error("bad status code");
endmodule

bind multilevel_feedback_queue_scheduler_core mlfq_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (cmd_in.valid),
  .in_ready_i    (cmd_in.ready),
  .out_valid_i   (res_out.valid),
  .out_ready_i   (res_out.ready),
  .out_payload_i (res_out.payload)
);
